### hdl/mexp_pkg.sv
// ----------------------------------------------------------------------------
// mexp_pkg
// Shared constants, microcode types and the control store of the modular
// exponentiation unit.
// ----------------------------------------------------------------------------
package mexp_pkg;

    // Field widths and defaults
    localparam int          BASE_BITS     = 32;
    localparam int          EXP_IN_BITS   = 32;
    localparam int          EXP_BITS_DEF  = 32;
    localparam int          MOD_BITS_DEF  = 31;
    localparam logic [31:0] MODULUS_RESET = 32'd1000000007;

    localparam int STEP_W = 4;

    // Sequencer steps (control store addresses)
    typedef enum logic [STEP_W-1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_RBASE,
        ST_SETB,
        ST_SQ,
        ST_SQRUN,
        ST_SQEND,
        ST_MU,
        ST_MURUN,
        ST_MUEND,
        ST_NEXT,
        ST_DONE,
        ST_DRET,
        ST_ZERO,
        ST_ZRET
    } t_step;

    // Datapath operations
    typedef enum logic [3:0] {
        UOP_NOP,
        UOP_LOAD,
        UOP_MSTEP,
        UOP_SETB,
        UOP_SQ,
        UOP_MU,
        UOP_ACC,
        UOP_SHIFT,
        UOP_OUT_ACC,
        UOP_OUT_ZERO
    } t_uop;

    // Jump conditions
    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_REQ,
        C_MOD_LOW,
        C_MUL_MORE,
        C_EBIT_CLEAR,
        C_EXP_MORE,
        C_OUT_BUSY
    } t_cond;

    typedef struct packed {
        t_uop  op;
        t_cond cond;
        t_step jump;
    } t_uword;

    // Control store: jump to 'jump' when 'cond' holds, else step on
    function automatic t_uword f_urom(input t_step s);
        t_uword w;
        unique case (s)
            ST_IDLE:  w = '{UOP_LOAD,     C_NO_REQ,     ST_IDLE};
            ST_CHECK: w = '{UOP_NOP,      C_MOD_LOW,    ST_ZERO};
            ST_RBASE: w = '{UOP_MSTEP,    C_MUL_MORE,   ST_RBASE};
            ST_SETB:  w = '{UOP_SETB,     C_NEVER,      ST_IDLE};
            ST_SQ:    w = '{UOP_SQ,       C_NEVER,      ST_IDLE};
            ST_SQRUN: w = '{UOP_MSTEP,    C_MUL_MORE,   ST_SQRUN};
            ST_SQEND: w = '{UOP_ACC,      C_EBIT_CLEAR, ST_NEXT};
            ST_MU:    w = '{UOP_MU,       C_NEVER,      ST_IDLE};
            ST_MURUN: w = '{UOP_MSTEP,    C_MUL_MORE,   ST_MURUN};
            ST_MUEND: w = '{UOP_ACC,      C_NEVER,      ST_IDLE};
            ST_NEXT:  w = '{UOP_SHIFT,    C_EXP_MORE,   ST_SQ};
            ST_DONE:  w = '{UOP_OUT_ACC,  C_OUT_BUSY,   ST_DONE};
            ST_DRET:  w = '{UOP_NOP,      C_ALWAYS,     ST_IDLE};
            ST_ZERO:  w = '{UOP_OUT_ZERO, C_OUT_BUSY,   ST_ZERO};
            ST_ZRET:  w = '{UOP_NOP,      C_ALWAYS,     ST_IDLE};
            default:  w = '{UOP_NOP,      C_ALWAYS,     ST_IDLE};
        endcase
        return w;
    endfunction

endpackage

### hdl/modular_exponentiation_unit.sv
// ----------------------------------------------------------------------------
// modular_exponentiation_unit
// Computes base^exponent mod modulus by left-to-right square-and-multiply,
// under control of a small microcoded sequencer.
// ----------------------------------------------------------------------------
// One request at a time. A request runs a set-up and a wrap-up (the base is
// first reduced bit by bit), then per exponent bit a squaring and, when the
// bit is set, a multiply, plus any wait for the result register to drain. The
// run time is set by the shared interleaved modular multiplier, which retires
// one multiplier bit per cycle with a double compare-and-subtract. A modulus
// below two gives a result of zero. A new request is taken as soon as the
// sequencer is back at idle, while the last result may still wait in the
// output register. The modulus register may only be written while the unit
// is idle.
module modular_exponentiation_unit #(
    parameter int EXP_BITS = mexp_pkg::EXP_BITS_DEF,
    parameter int MOD_BITS = mexp_pkg::MOD_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration
    input  logic                            i_cfg_we,
    input  logic [MOD_BITS-1:0]             i_cfg_wdata,
    // request channel
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [mexp_pkg::BASE_BITS-1:0]   i_base,
    input  logic [mexp_pkg::EXP_IN_BITS-1:0] i_exponent,
    // result channel
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [MOD_BITS-1:0]             o_power_residue
);
    import mexp_pkg::*;

    localparam int CNT_W  = $clog2(BASE_BITS + 1);
    localparam int ECNT_W = $clog2(EXP_BITS + 1);
    localparam int SUM_W  = MOD_BITS + 3;

    // Sequencer
    t_step  r_pc, n_pc;
    t_uword uw;
    logic   take;

    // Datapath registers
    logic [MOD_BITS-1:0]  r_mod;
    logic [MOD_BITS-1:0]  r_base;
    logic [MOD_BITS-1:0]  r_acc;
    logic [MOD_BITS-1:0]  r_x;
    logic [MOD_BITS-1:0]  r_r;
    logic [BASE_BITS-1:0] r_y;
    logic [CNT_W-1:0]     r_cnt;
    logic [EXP_BITS-1:0]  r_exp;
    logic [ECNT_W-1:0]    r_ecnt;
    logic                 r_ovalid;
    logic [MOD_BITS-1:0]  r_res;

    logic                 accept;
    logic                 out_free;
    logic                 mod_low;

    // Multiplier step: r = (2r + ybit*x) mod m, sum stays below 3m
    logic [SUM_W-1:0]     s_sum, s_d1, s_d2;
    logic [MOD_BITS-1:0]  s_next;

    assign accept   = i_valid && (r_pc == ST_IDLE);
    assign o_ready  = (r_pc == ST_IDLE);
    assign out_free = !r_ovalid || i_ready;
    assign mod_low  = (r_mod[MOD_BITS-1:1] == '0);

    assign o_valid         = r_ovalid;
    assign o_power_residue = r_res;

    always_comb begin
        s_sum = {2'b00, r_r, 1'b0}
              + (r_y[BASE_BITS-1] ? SUM_W'(r_x) : SUM_W'(0));
        s_d1  = s_sum - SUM_W'(r_mod);
        s_d2  = s_sum - SUM_W'({r_mod, 1'b0});
        priority if (!s_d2[SUM_W-1]) begin
            s_next = s_d2[MOD_BITS-1:0];
        end else if (!s_d1[SUM_W-1]) begin
            s_next = s_d1[MOD_BITS-1:0];
        end else begin
            s_next = s_sum[MOD_BITS-1:0];
        end
    end

    // Control word fetch and next step
    always_comb begin
        uw = f_urom(r_pc);
        unique case (uw.cond)
            C_NEVER:      take = 1'b0;
            C_ALWAYS:     take = 1'b1;
            C_NO_REQ:     take = !i_valid;
            C_MOD_LOW:    take = mod_low;
            C_MUL_MORE:   take = (r_cnt != CNT_W'(1));
            C_EBIT_CLEAR: take = !r_exp[EXP_BITS-1];
            C_EXP_MORE:   take = (r_ecnt != ECNT_W'(1));
            C_OUT_BUSY:   take = !out_free;
            default:      take = 1'b0;
        endcase
        n_pc = take ? uw.jump : t_step'(STEP_W'(r_pc) + STEP_W'(1));
    end

    // Step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= ST_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    // Modulus register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod <= MOD_BITS'(MODULUS_RESET);
        end else if (i_cfg_we) begin
            r_mod <= i_cfg_wdata;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if ((uw.op == UOP_OUT_ACC || uw.op == UOP_OUT_ZERO) && out_free) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (uw.op == UOP_OUT_ACC && out_free) begin
            r_res <= r_acc;
        end else if (uw.op == UOP_OUT_ZERO && out_free) begin
            r_res <= '0;
        end
    end

    // Datapath driven by the control word
    always_ff @(posedge i_clk) begin
        unique case (uw.op)
            UOP_LOAD: begin
                if (accept) begin
                    // base mod m computed as 1 * base mod m
                    r_x   <= MOD_BITS'(1);
                    r_y   <= i_base;
                    r_r   <= '0;
                    r_cnt <= CNT_W'(BASE_BITS);
                    r_exp <= EXP_BITS'(i_exponent);
                end
            end
            UOP_MSTEP: begin
                r_r   <= s_next;
                r_y   <= r_y << 1;
                r_cnt <= r_cnt - CNT_W'(1);
            end
            UOP_SETB: begin
                r_base <= r_r;
                r_acc  <= MOD_BITS'(1);
                r_ecnt <= ECNT_W'(EXP_BITS);
            end
            UOP_SQ: begin
                r_x   <= r_acc;
                r_y   <= BASE_BITS'(r_acc) << (BASE_BITS - MOD_BITS);
                r_r   <= '0;
                r_cnt <= CNT_W'(MOD_BITS);
            end
            UOP_MU: begin
                r_x   <= r_base;
                r_y   <= BASE_BITS'(r_acc) << (BASE_BITS - MOD_BITS);
                r_r   <= '0;
                r_cnt <= CNT_W'(MOD_BITS);
            end
            UOP_ACC: begin
                r_acc <= r_r;
            end
            UOP_SHIFT: begin
                r_exp  <= r_exp << 1;
                r_ecnt <= r_ecnt - ECNT_W'(1);
            end
            UOP_NOP, UOP_OUT_ACC, UOP_OUT_ZERO: begin
            end
            default: begin
            end
        endcase
    end

endmodule

### hdl/mexp_checker.sv
// ----------------------------------------------------------------------------
// mexp_checker
// Port-level checks on the modular exponentiation unit, bound to the top.
// ----------------------------------------------------------------------------
module mexp_checker #(
    parameter int MOD_BITS = mexp_pkg::MOD_BITS_DEF
) (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_cfg_we,
    input logic [MOD_BITS-1:0] i_cfg_wdata,
    input logic                i_valid,
    input logic                o_ready,
    input logic                o_valid,
    input logic                i_ready,
    input logic [MOD_BITS-1:0] o_power_residue
);
    import mexp_pkg::*;

    // Shadow of the modulus register
    logic [MOD_BITS-1:0] r_mod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod <= MOD_BITS'(MODULUS_RESET);
        end else if (i_cfg_we) begin
            r_mod <= i_cfg_wdata;
        end
    end

    // No result shows straight after reset
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_power_residue))
        else $error("stalled result changed");

    // Only one request in flight: ready drops after an accepted request
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("second request taken while busy");

    // A result is always a proper residue of the current modulus
    a_residue_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_mod < MOD_BITS'(2) && o_power_residue == '0)
                 || (r_mod >= MOD_BITS'(2) && o_power_residue < r_mod))
        else $error("result not below modulus");

endmodule

bind modular_exponentiation_unit mexp_checker #(
    .MOD_BITS (MOD_BITS)
) u_mexp_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_cfg_we        (i_cfg_we),
    .i_cfg_wdata     (i_cfg_wdata),
    .i_valid         (i_valid),
    .o_ready         (o_ready),
    .o_valid         (o_valid),
    .i_ready         (i_ready),
    .o_power_residue (o_power_residue)
);
